// ===== rtl/core/hjc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hangul jamo composer package
// Shared types, code constants and jamo lookup functions for the composer.
// ----------------------------------------------------------------------------
package hjc_pkg;

    localparam logic [15:0] JAMO_BASE   = 16'h3130;
    localparam logic [15:0] CONS_FIRST  = 16'h3131;
    localparam logic [15:0] VOWEL_FIRST = 16'h314F;
    localparam logic [15:0] JAMO_LAST   = 16'h3163;
    localparam logic [15:0] SYL_BASE    = 16'hAC00;
    localparam logic [5:0]  VOWEL_OFF   = 6'h1F;
    localparam logic [5:0]  NUM_MEDIAL  = 6'd21;

    // One keystroke or backspace.
    typedef struct packed {
        logic        mode;
        logic [15:0] jamo_code;
    } hjc_in_t;

    // One result.
    typedef struct packed {
        logic [15:0] replace_code;
        logic [15:0] insert_code;
    } hjc_out_t;

    // Parts of the syllable under composition, each a jamo offset (0 = empty).
    typedef struct packed {
        logic [5:0] initial_part;
        logic [5:0] vowel_first;
        logic [5:0] vowel_second;
        logic [5:0] final_first;
        logic [5:0] final_second;
    } hjc_parts_t;

    typedef struct packed {
        logic load_in;
        logic decide;
        logic index;
        logic capture_rep;
        logic capture_ins;
        logic reload_view;
        logic out_load;
    } hjc_cmd_t;

    typedef struct packed {
        logic rep_en;
        logic ins_en;
    } hjc_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_INDEX,
        ST_SYLLABLE,
        ST_HOLD
    } hjc_state_t;

    // Returns {valid, lead index} for a consonant offset.
    function automatic logic [5:0] lead_lookup(input logic [5:0] off);
        logic [5:0] r;
        begin
            case (off)
                6'd1:    r = {1'b1, 5'd0};
                6'd2:    r = {1'b1, 5'd1};
                6'd4:    r = {1'b1, 5'd2};
                6'd7:    r = {1'b1, 5'd3};
                6'd8:    r = {1'b1, 5'd4};
                6'd9:    r = {1'b1, 5'd5};
                6'd17:   r = {1'b1, 5'd6};
                6'd18:   r = {1'b1, 5'd7};
                6'd19:   r = {1'b1, 5'd8};
                6'd21:   r = {1'b1, 5'd9};
                6'd22:   r = {1'b1, 5'd10};
                6'd23:   r = {1'b1, 5'd11};
                6'd24:   r = {1'b1, 5'd12};
                6'd25:   r = {1'b1, 5'd13};
                6'd26:   r = {1'b1, 5'd14};
                6'd27:   r = {1'b1, 5'd15};
                6'd28:   r = {1'b1, 5'd16};
                6'd29:   r = {1'b1, 5'd17};
                6'd30:   r = {1'b1, 5'd18};
                default: r = 6'd0;
            endcase
            return r;
        end
    endfunction

    // Returns {valid, tail index} for a consonant offset.
    function automatic logic [5:0] tail_lookup(input logic [5:0] off);
        logic [5:0] r;
        begin
            r = 6'd0;
            if (off >= 6'd1 && off <= 6'd7) begin
                r = {1'b1, off[4:0]};
            end else if (off >= 6'd9 && off <= 6'd18) begin
                r = {1'b1, 5'(off - 6'd1)};
            end else if (off >= 6'd20 && off <= 6'd24) begin
                r = {1'b1, 5'(off - 6'd2)};
            end else if (off >= 6'd26 && off <= 6'd30) begin
                r = {1'b1, 5'(off - 6'd3)};
            end
            return r;
        end
    endfunction

    // Compound vowel of two vowel offsets, zero when they do not combine.
    function automatic logic [5:0] vowel_pair(input logic [5:0] a, input logic [5:0] b);
        logic [5:0] r;
        begin
            r = 6'd0;
            if (a == 6'h27) begin
                if (b == 6'h1F) r = 6'h28;
                if (b == 6'h20) r = 6'h29;
                if (b == 6'h33) r = 6'h2A;
            end else if (a == 6'h2C) begin
                if (b == 6'h23) r = 6'h2D;
                if (b == 6'h24) r = 6'h2E;
                if (b == 6'h33) r = 6'h2F;
            end else if (a == 6'h31) begin
                if (b == 6'h33) r = 6'h32;
            end
            return r;
        end
    endfunction

    // Compound final of two consonant offsets, zero when they do not combine.
    function automatic logic [5:0] final_pair(input logic [5:0] a, input logic [5:0] b);
        logic [5:0] r;
        begin
            r = 6'd0;
            if (a == 6'h01 && b == 6'h15) r = 6'h03;
            if (a == 6'h04) begin
                if (b == 6'h18) r = 6'h05;
                if (b == 6'h1E) r = 6'h06;
            end
            if (a == 6'h09) begin
                if (b == 6'h01) r = 6'h0A;
                if (b == 6'h11) r = 6'h0B;
                if (b == 6'h12) r = 6'h0C;
                if (b == 6'h15) r = 6'h0D;
                if (b == 6'h1C) r = 6'h0E;
                if (b == 6'h1D) r = 6'h0F;
                if (b == 6'h1E) r = 6'h10;
            end
            if (a == 6'h12 && b == 6'h15) r = 6'h14;
            return r;
        end
    endfunction

    // Compatibility jamo code of an offset, zero for an empty part.
    function automatic logic [15:0] jamo_of(input logic [5:0] off);
        begin
            return (off == 6'd0) ? 16'd0 : (JAMO_BASE + {10'd0, off});
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hjc_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hangul jamo composer stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface hjc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/hjc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hangul jamo composer controller
// Sequences decision, the two-step syllable encode and the output handoff.
// ----------------------------------------------------------------------------
module hjc_ctrl
    import hjc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      keys_valid,
    output logic           keys_ready,
    output logic           codes_valid,
    input  wire logic      codes_ready,
    input  wire hjc_stat_t stat,
    output hjc_cmd_t       cmd
);

    hjc_state_t state_reg, state_next;
    logic       cur_rep_reg, cur_rep_next;
    logic       need_ins_reg, need_ins_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || codes_ready;

    always_comb
    begin
        state_next    = state_reg;
        cur_rep_next  = cur_rep_reg;
        need_ins_next = need_ins_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (keys_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cur_rep_next  = stat.rep_en;
                need_ins_next = stat.rep_en && stat.ins_en;
                state_next    = (stat.rep_en || stat.ins_en) ? ST_INDEX : ST_HOLD;
            end
            ST_INDEX:
            begin
                state_next = ST_SYLLABLE;
            end
            ST_SYLLABLE:
            begin
                if (need_ins_reg)
                begin
                    cur_rep_next  = 1'b0;
                    need_ins_next = 1'b0;
                    state_next    = ST_INDEX;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        keys_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                keys_ready  = 1'b1;
                cmd.load_in = keys_valid;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            ST_INDEX:
            begin
                cmd.index = 1'b1;
            end
            ST_SYLLABLE:
            begin
                cmd.capture_rep = cur_rep_reg;
                cmd.capture_ins = !cur_rep_reg;
                cmd.reload_view = need_ins_reg;
            end
            ST_HOLD:
            begin
                cmd.out_load = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (codes_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign codes_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_rep_reg   <= 1'b0;
            need_ins_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_rep_reg   <= cur_rep_next;
            need_ins_reg  <= need_ins_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/hjc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hangul jamo composer datapath
// Composition state, transition logic, syllable encoder and result registers.
// ----------------------------------------------------------------------------
module hjc_datapath
    import hjc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire hjc_in_t  keys_data,
    output hjc_out_t      codes_data,
    input  wire hjc_cmd_t cmd,
    output hjc_stat_t     stat
);

    hjc_parts_t  state_reg, view_reg;
    hjc_in_t     in_reg;
    hjc_out_t    out_reg;
    logic [15:0] pend_rep_reg, pend_ins_reg;
    logic        syl_reg;
    logic [8:0]  idx_reg;
    logic [4:0]  fi_reg;
    logic [15:0] lone_reg;

    // Transition decision.
    hjc_parts_t  cur, part_a, part_b;
    logic [5:0]  j_off, moved, l_lead, m_lead, j_tail;
    logic        in_range, is_vowel, busy;
    logic        rep_en, ins_en, changes;

    always_comb
    begin
        cur      = state_reg;
        j_off    = 6'(in_reg.jamo_code[5:0] - 6'h30);
        in_range = (in_reg.jamo_code >= CONS_FIRST) && (in_reg.jamo_code <= JAMO_LAST);
        is_vowel = in_reg.jamo_code >= VOWEL_FIRST;
        busy     = (cur.initial_part != 6'd0) || (cur.vowel_first != 6'd0);
        moved    = (cur.final_second != 6'd0) ? cur.final_second : cur.final_first;
        l_lead   = lead_lookup(cur.initial_part);
        m_lead   = lead_lookup(moved);
        j_tail   = tail_lookup(j_off);
        part_a   = cur;
        part_b   = cur;
        rep_en   = 1'b0;
        ins_en   = 1'b0;
        changes  = 1'b0;
        if (in_reg.mode)
        begin
            changes = 1'b1;
            rep_en  = 1'b1;
            if (cur.final_second != 6'd0)
                part_b.final_second = 6'd0;
            else if (cur.final_first != 6'd0)
                part_b.final_first = 6'd0;
            else if (cur.vowel_second != 6'd0)
                part_b.vowel_second = 6'd0;
            else if (cur.vowel_first != 6'd0)
                part_b.vowel_first = 6'd0;
            else
                part_b.initial_part = 6'd0;
            part_a = part_b;
        end
        else if (in_range)
        begin
            changes = 1'b1;
            if (is_vowel)
            begin
                if ((cur.initial_part != 6'd0) && (cur.vowel_first == 6'd0) && l_lead[5])
                begin
                    part_b.vowel_first = j_off;
                    rep_en             = 1'b1;
                end
                else if ((cur.vowel_first != 6'd0) && (cur.final_first == 6'd0) &&
                         (cur.vowel_second == 6'd0) &&
                         (vowel_pair(cur.vowel_first, j_off) != 6'd0))
                begin
                    part_b.vowel_second = j_off;
                    rep_en              = 1'b1;
                end
                else if ((cur.initial_part != 6'd0) && (cur.vowel_first != 6'd0) &&
                         (cur.final_first != 6'd0) && m_lead[5])
                begin
                    // The last final moves over to start the next syllable.
                    if (cur.final_second != 6'd0)
                        part_a.final_second = 6'd0;
                    else
                        part_a.final_first = 6'd0;
                    part_b              = '0;
                    part_b.initial_part = moved;
                    part_b.vowel_first  = j_off;
                    rep_en              = 1'b1;
                    ins_en              = 1'b1;
                end
                else
                begin
                    if (busy)
                        part_b = '0;
                    part_b.vowel_first = j_off;
                    ins_en             = 1'b1;
                end
            end
            else
            begin
                if (!busy)
                begin
                    part_b.initial_part = j_off;
                    ins_en              = 1'b1;
                end
                else if ((cur.initial_part != 6'd0) && (cur.vowel_first != 6'd0) &&
                         (cur.final_first == 6'd0) && j_tail[5])
                begin
                    part_b.final_first = j_off;
                    rep_en             = 1'b1;
                end
                else if ((cur.initial_part != 6'd0) && (cur.vowel_first != 6'd0) &&
                         (cur.final_first != 6'd0) && (cur.final_second == 6'd0) &&
                         (final_pair(cur.final_first, j_off) != 6'd0))
                begin
                    part_b.final_second = j_off;
                    rep_en              = 1'b1;
                end
                else
                begin
                    part_b              = '0;
                    part_b.initial_part = j_off;
                    ins_en              = 1'b1;
                end
            end
            if (!rep_en)
                part_a = part_b;
            else if (!ins_en)
                part_a = part_b;
        end
    end

    assign stat.rep_en = rep_en;
    assign stat.ins_en = ins_en;

    // Encoder, first step: lead, medial and tail indexes of the viewed parts.
    logic [5:0]  vow, fin, v_lead, f_tail, med_diff, med;
    logic [4:0]  li, fi;
    logic        is_syl;
    logic [8:0]  idx;
    logic [15:0] lone;

    always_comb
    begin
        vow      = (view_reg.vowel_second != 6'd0) ?
                   vowel_pair(view_reg.vowel_first, view_reg.vowel_second) :
                   view_reg.vowel_first;
        if (view_reg.final_first == 6'd0)
            fin = 6'd0;
        else if (view_reg.final_second == 6'd0)
            fin = view_reg.final_first;
        else
            fin = final_pair(view_reg.final_first, view_reg.final_second);
        v_lead   = lead_lookup(view_reg.initial_part);
        f_tail   = tail_lookup(fin);
        li       = v_lead[5] ? v_lead[4:0] : 5'd0;
        fi       = ((fin != 6'd0) && f_tail[5]) ? f_tail[4:0] : 5'd0;
        med_diff = 6'(vow - VOWEL_OFF);
        if (vow < VOWEL_OFF)
            med = 6'd0;
        else if (med_diff >= NUM_MEDIAL)
            med = 6'(med_diff - NUM_MEDIAL);
        else
            med = med_diff;
        idx      = 9'(li * 9'd21) + {3'd0, med};
        is_syl   = (view_reg.initial_part != 6'd0) && (view_reg.vowel_first != 6'd0);
        if (view_reg.initial_part != 6'd0)
            lone = jamo_of(view_reg.initial_part);
        else if (view_reg.vowel_first != 6'd0)
            lone = jamo_of(vow);
        else
            lone = 16'd0;
    end

    // Encoder, second step: base + index * 28 + tail.
    logic [15:0] shown;

    assign shown = syl_reg ?
                   (SYL_BASE + {2'd0, idx_reg, 5'd0} - {5'd0, idx_reg, 2'd0} + {11'd0, fi_reg}) :
                   lone_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (cmd.decide && changes)
        begin
            state_reg <= part_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            in_reg <= keys_data;
        if (cmd.decide)
        begin
            view_reg     <= rep_en ? part_a : part_b;
            pend_rep_reg <= 16'd0;
            pend_ins_reg <= 16'd0;
        end
        if (cmd.reload_view)
            view_reg <= state_reg;
        if (cmd.index)
        begin
            syl_reg  <= is_syl;
            idx_reg  <= idx;
            fi_reg   <= fi;
            lone_reg <= lone;
        end
        if (cmd.capture_rep)
            pend_rep_reg <= shown;
        if (cmd.capture_ins)
            pend_ins_reg <= shown;
        if (cmd.out_load)
        begin
            out_reg.replace_code <= pend_rep_reg;
            out_reg.insert_code  <= pend_ins_reg;
        end
    end

    assign codes_data = out_reg;

endmodule
`default_nettype wire

// ===== rtl/core/hangul_jamo_composer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hangul jamo composer
// Two-set Hangul input automaton: composes jamo keystrokes into syllables.
// ----------------------------------------------------------------------------
// Sequence: a keystroke is accepted, decided, then sent through the index and syllable
// steps of the encoder, twice when a final consonant moves to a new syllable; an ignored
// code skips the encoder. The result then waits for a free output slot. The controller
// steps one item at a time through the shared two-step syllable encoder and takes no new
// key before the last one is through. A new key is taken while the last result waits.
// Reset (rst_n low, asynchronous) empties the composition and the output slot.
// ----------------------------------------------------------------------------
module hangul_jamo_composer
    import hjc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    hjc_stream_if.sink   keys,
    hjc_stream_if.source codes
);

    // The controller owns the handshakes and the step sequence; the datapath
    // holds the composition and the encoder and only acts on its commands.
    hjc_cmd_t  cmd;
    hjc_stat_t stat;

    hjc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .keys_valid  (keys.valid),
        .keys_ready  (keys.ready),
        .codes_valid (codes.valid),
        .codes_ready (codes.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // The result sits in an output register, so the next keystroke can be
    // decided and encoded while the previous transaction is still pending.
    hjc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .keys_data  (keys.data),
        .codes_data (codes.data),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule
`default_nettype wire

// ===== rtl/core/hjc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hangul jamo composer checker
// Port-level assertions on the composer, attached by bind.
// ----------------------------------------------------------------------------
module hjc_checker
    import hjc_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     keys_valid,
    input wire logic     keys_ready,
    input wire logic     codes_valid,
    input wire logic     codes_ready,
    input wire hjc_out_t codes_data
);

    // After taking a key the block is busy with it and does not take a key in the next cycle.
    a_busy_after_key: assert property (@(posedge clk) disable iff (!rst_n)
        keys_valid && keys_ready |=> !keys_ready)
        else $error("key accepted on two consecutive cycles");

    // A new result is only produced while no key is being taken.
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(codes_valid) |-> $past(!keys_ready))
        else $error("result appeared without a busy cycle");

    // Codes never exceed the last Hangul syllable.
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        codes_valid |-> (codes_data.replace_code <= 16'hD7A3) &&
                        (codes_data.insert_code <= 16'hD7A3))
        else $error("result code out of range");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        codes_valid && !codes_ready |=> codes_valid && $stable(codes_data))
        else $error("stalled result changed");

endmodule

bind hangul_jamo_composer hjc_checker u_hjc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .keys_valid  (keys.valid),
    .keys_ready  (keys.ready),
    .codes_valid (codes.valid),
    .codes_ready (codes.ready),
    .codes_data  (codes.data)
);
`default_nettype wire
